// ===== rtl/slip_frame_decoder_unit_assert.svh =====
// ---------------------------------------------------------------------------
// SLIP frame decoder assertion macros
// Shared property forms used by the decoder top level.
// ---------------------------------------------------------------------------
`ifndef SLIP_FRAME_DECODER_UNIT_ASSERT_SVH
`define SLIP_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slip decoder implication check failed");

// next-cycle implication, checked outside reset
`define SFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slip decoder next-cycle check failed");

`endif

// ===== rtl/slip_dec_pkg.sv =====
// ---------------------------------------------------------------------------
// SLIP decoder package
// Byte codes, status codes, register map and the structs between modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slip_dec_pkg;

	// framing bytes
	localparam logic [7:0] FEND = 8'hC0;
	localparam logic [7:0] FESC = 8'hDB;
	localparam logic [7:0] TEND = 8'hDC;
	localparam logic [7:0] TESC = 8'hDD;
	localparam logic [7:0] TLF  = 8'hDE;
	localparam logic [7:0] TCR  = 8'hDF;
	localparam logic [7:0] LF   = 8'h0A;
	localparam logic [7:0] CR   = 8'h0D;

	// frame length limits
	localparam int unsigned LEN_W       = 17;
	localparam int unsigned IDX_W       = 16;
	localparam logic [LEN_W-1:0] MAX_PAYLOAD = 17'd65536;
	localparam logic [LEN_W-1:0] LEN_RESET   = 17'd1;

	// register map
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_EXP_LEN = 1'b0;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_FAIL  = 2'd2
	} status_t;

	// one decoded result word
	typedef struct packed {
		logic             valid;
		logic             has_byte;
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
		logic             done;
		status_t          status;
	} result_t;

	// decoder state for observation
	typedef struct packed {
		logic in_frame;
		logic esc_pending;
	} dec_state_t;

endpackage

`default_nettype wire

// ===== rtl/slip_frame_decoder_unit.sv =====
// Path: input register, decoder core, result register driving the outputs.
// Throughput: one word per cycle; the input register and the result register
// each move on every cycle the result side takes words.
// Words that cause no result (hunting bytes, ESC) leave nothing at the outputs.
// Reset (arst_n low, asynchronous): hunting for END, no escape, count zero,
// expected_length 1, both pipeline registers empty.
// ---------------------------------------------------------------------------
// SLIP frame decoder
// Input register, decoder core with frame state, and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slip_frame_decoder_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration port
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [slip_dec_pkg::ADDR_W-1:0]     paddr,
	input  wire  [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// receive channel
	input  wire                                 rx_valid,
	output logic                                rx_ready,
	input  wire  [7:0]                          rx_byte,
	input  wire                                 read_failed,
	// result channel
	output logic                                res_valid,
	input  wire                                 res_ready,
	output logic                                has_byte,
	output logic [7:0]                          payload_byte,
	output logic [slip_dec_pkg::IDX_W-1:0]      byte_index,
	output logic                                frame_done,
	output logic [1:0]                          status
);

	logic                              valid_s1;
	logic [7:0]                        rx_byte_s1;
	logic                              read_failed_s1;
	logic                              s1_adv;
	logic [slip_dec_pkg::LEN_W-1:0]    eff_len;
	slip_dec_pkg::result_t             res;
	slip_dec_pkg::dec_state_t          dec_state;

	logic                              res_valid_q;
	logic                              has_byte_q;
	logic [7:0]                        payload_byte_q;
	logic [slip_dec_pkg::IDX_W-1:0]    byte_index_q;
	logic                              frame_done_q;
	slip_dec_pkg::status_t             status_q;

	assign pready = 1'b1;

	slip_dec_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.eff_len (eff_len)
	);

	// stage 1 moves when its word needs no slot or the result slot frees up
	assign s1_adv   = valid_s1 && (!res.valid || !res_valid_q || res_ready);
	assign rx_ready = !valid_s1 || s1_adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			rx_byte_s1     <= rx_byte;
			read_failed_s1 <= read_failed;
		end
	end

	slip_dec_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (s1_adv),
		.rx_byte_s1     (rx_byte_s1),
		.read_failed_s1 (read_failed_s1),
		.eff_len        (eff_len),
		.res            (res),
		.state          (dec_state)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && res.valid) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res.valid) begin
			has_byte_q     <= res.has_byte;
			payload_byte_q <= res.data;
			byte_index_q   <= res.idx;
			frame_done_q   <= res.done;
			status_q       <= res.status;
		end
	end

	assign res_valid    = res_valid_q;
	assign has_byte     = has_byte_q;
	assign payload_byte = payload_byte_q;
	assign byte_index   = byte_index_q;
	assign frame_done   = frame_done_q;
	assign status       = status_q;

	// checks
	`include "slip_frame_decoder_unit_assert.svh"

	`SFD_ASSERT_IMP(a_ok_carries_byte, res_valid_q && frame_done_q && status_q == slip_dec_pkg::ST_OK, has_byte_q)
	`SFD_ASSERT_IMP(a_empty_ends_frame, res_valid_q && !has_byte_q, frame_done_q)
	`SFD_ASSERT_NXT(a_done_hunts, s1_adv && res.valid && res.done, !dec_state.in_frame)
	`SFD_ASSERT_IMP(a_esc_in_frame, dec_state.esc_pending, dec_state.in_frame)

endmodule

`default_nettype wire

// ===== rtl/slip_dec_cfg.sv =====
// ---------------------------------------------------------------------------
// SLIP decoder register block
// APB-style expected-length register plus the clamped frame length.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slip_dec_cfg (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [slip_dec_pkg::ADDR_W-1:0]     paddr,
	input  wire  [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic [slip_dec_pkg::LEN_W-1:0]      eff_len
);

	logic [slip_dec_pkg::LEN_W-1:0] exp_len_q;
	logic [slip_dec_pkg::LEN_W-1:0] eff_len_q;
	logic [slip_dec_pkg::LEN_W-1:0] wr_len;
	logic [slip_dec_pkg::LEN_W-1:0] wr_eff;
	logic                           wr_en;

	// register write on the access cycle
	assign wr_en  = psel && penable && pwrite && (paddr[2] == slip_dec_pkg::REG_EXP_LEN);
	assign wr_len = pwdata[slip_dec_pkg::LEN_W-1:0];

	// zero means one, large values saturate
	always_comb begin
		if (wr_len == '0) begin
			wr_eff = slip_dec_pkg::LEN_RESET;
		end else if (wr_len > slip_dec_pkg::MAX_PAYLOAD) begin
			wr_eff = slip_dec_pkg::MAX_PAYLOAD;
		end else begin
			wr_eff = wr_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= slip_dec_pkg::LEN_RESET;
			eff_len_q <= slip_dec_pkg::LEN_RESET;
		end else if (wr_en) begin
			exp_len_q <= wr_len;
			eff_len_q <= wr_eff;
		end
	end

	// readback
	always_comb begin
		prdata = '0;
		if (paddr[2] == slip_dec_pkg::REG_EXP_LEN) begin
			prdata = {{(32-slip_dec_pkg::LEN_W){1'b0}}, exp_len_q};
		end
	end

	assign eff_len = eff_len_q;

endmodule

`default_nettype wire

// ===== rtl/slip_dec_core.sv =====
// ---------------------------------------------------------------------------
// SLIP decoder core
// Frame hunt, unescape and byte count for one word per cycle while advance is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slip_dec_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 advance,
	input  wire  [7:0]                          rx_byte_s1,
	input  wire                                 read_failed_s1,
	input  wire  [slip_dec_pkg::LEN_W-1:0]      eff_len,
	output slip_dec_pkg::result_t               res,
	output slip_dec_pkg::dec_state_t            state
);

	logic                           in_frame_q;
	logic                           esc_q;
	logic [slip_dec_pkg::LEN_W-1:0] count_q;

	logic                           in_frame_d;
	logic                           esc_d;
	logic [slip_dec_pkg::LEN_W-1:0] count_d;
	logic [slip_dec_pkg::LEN_W-1:0] count_inc;
	logic [7:0]                     unesc;

	assign count_inc = count_q + 1'b1;

	// escaped byte translation
	always_comb begin
		case (rx_byte_s1)
			slip_dec_pkg::TEND: unesc = slip_dec_pkg::FEND;
			slip_dec_pkg::TESC: unesc = slip_dec_pkg::FESC;
			slip_dec_pkg::TLF:  unesc = slip_dec_pkg::LF;
			slip_dec_pkg::TCR:  unesc = slip_dec_pkg::CR;
			default:            unesc = rx_byte_s1;
		endcase
	end

	// next state and result
	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		count_d    = count_q;
		res        = '0;
		res.status = slip_dec_pkg::ST_OK;
		if (read_failed_s1) begin
			in_frame_d = 1'b0;
			esc_d      = 1'b0;
			count_d    = '0;
			res.valid  = 1'b1;
			res.done   = 1'b1;
			res.status = slip_dec_pkg::ST_FAIL;
		end else if (!in_frame_q) begin
			// hunting: only END opens a frame
			if (rx_byte_s1 == slip_dec_pkg::FEND) begin
				in_frame_d = 1'b1;
				esc_d      = 1'b0;
				count_d    = '0;
			end
		end else if (rx_byte_s1 == slip_dec_pkg::FEND) begin
			// early END
			in_frame_d = 1'b0;
			esc_d      = 1'b0;
			count_d    = '0;
			res.valid  = 1'b1;
			res.done   = 1'b1;
			res.status = slip_dec_pkg::ST_SHORT;
		end else if (!esc_q && rx_byte_s1 == slip_dec_pkg::FESC) begin
			esc_d = 1'b1;
		end else begin
			esc_d        = 1'b0;
			res.valid    = 1'b1;
			res.has_byte = 1'b1;
			res.data     = esc_q ? unesc : rx_byte_s1;
			res.idx      = count_q[slip_dec_pkg::IDX_W-1:0];
			count_d      = count_inc;
			if (count_inc >= eff_len) begin
				res.done   = 1'b1;
				in_frame_d = 1'b0;
				count_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			count_q    <= '0;
		end else if (advance) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			count_q    <= count_d;
		end
	end

	assign state.in_frame    = in_frame_q;
	assign state.esc_pending = esc_q;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// SLIP frame decoder testbench
// Sends receive words through the valid/ready channel and checks every result
// word against an in-bench decoder or a table row. A short table covers the escape codes,
// early END, read failures and length corner cases. Random phases follow:
// well-formed frames, broken frames and line noise under several length
// settings, including a saturated one. Both sides stall in random bursts while idle_on is set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import slip_dec_pkg::*;

	localparam int CYCLE_LIMIT = 500_000;
	localparam logic [ADDR_W-1:0] LEN_ADDR = ADDR_W'({REG_EXP_LEN, 2'b00});

	// one result word as the decoder should emit it
	typedef struct packed {
		logic             has;
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
		logic             done;
		status_t          st;
	} slip_word_t;

	// how a table row is checked
	typedef enum logic [1:0] {
		CHK_NONE,
		CHK_MODEL,
		CHK_WORD
	} row_chk_t;

	typedef struct packed {
		logic        set_len;
		logic [31:0] len;
		logic [7:0]  rx;
		logic        fail;
		row_chk_t    chk;
		slip_word_t  want;
	} dir_row_t;

	localparam slip_word_t W_NONE  = '0;
	localparam slip_word_t W_FAIL  = '{1'b0, 8'h00, 16'd0, 1'b1, ST_FAIL};
	localparam slip_word_t W_SHORT = '{1'b0, 8'h00, 16'd0, 1'b1, ST_SHORT};

	localparam int N_DIRECTED = 27;
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		// read failure while hunting, byte ignored
		'{1'b0, 32'd0, FEND,  1'b1, CHK_WORD,  W_FAIL},
		// hunting drops non-END bytes
		'{1'b0, 32'd0, 8'h00, 1'b0, CHK_NONE,  W_NONE},
		// END right after the opening END
		'{1'b0, 32'd0, FEND,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, FEND,  1'b0, CHK_WORD,  W_SHORT},
		// reset length is 1
		'{1'b0, 32'd0, FEND,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, 8'hFF, 1'b0, CHK_WORD,  '{1'b1, 8'hFF, 16'd0, 1'b1, ST_OK}},
		// trailing END opens the next frame
		'{1'b0, 32'd0, FEND,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, 8'h00, 1'b0, CHK_WORD,  '{1'b1, 8'h00, 16'd0, 1'b1, ST_OK}},
		// length 4: all four escape codes
		'{1'b1, 32'd4, FEND,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, FESC,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, TEND,  1'b0, CHK_WORD,  '{1'b1, FEND, 16'd0, 1'b0, ST_OK}},
		'{1'b0, 32'd0, FESC,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, TESC,  1'b0, CHK_MODEL, W_NONE},
		'{1'b0, 32'd0, FESC,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, TLF,   1'b0, CHK_MODEL, W_NONE},
		'{1'b0, 32'd0, FESC,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, TCR,   1'b0, CHK_MODEL, W_NONE},
		// escaped byte outside the code set passes as itself
		'{1'b0, 32'd0, FEND,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, FESC,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, FESC,  1'b0, CHK_WORD,  '{1'b1, FESC, 16'd0, 1'b0, ST_OK}},
		// END with an escape pending: escape dropped, frame short
		'{1'b0, 32'd0, FESC,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, FEND,  1'b0, CHK_WORD,  W_SHORT},
		// read failure inside a frame
		'{1'b0, 32'd0, FEND,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, 8'h7E, 1'b0, CHK_MODEL, W_NONE},
		'{1'b0, 32'd0, 8'hFF, 1'b1, CHK_WORD,  W_FAIL},
		// length 0 acts as 1
		'{1'b1, 32'd0, FEND,  1'b0, CHK_NONE,  W_NONE},
		'{1'b0, 32'd0, 8'h5A, 1'b0, CHK_WORD,  '{1'b1, 8'h5A, 16'd0, 1'b1, ST_OK}}
	};

	// DUT ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              rx_valid = 1'b0;
	logic              rx_ready;
	logic [7:0]        rx_byte = 8'h00;
	logic              read_failed = 1'b0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	logic              has_byte;
	logic [7:0]        payload_byte;
	logic [IDX_W-1:0]  byte_index;
	logic              frame_done;
	logic [1:0]        status;

	// decoder state as the bench sees it
	logic [LEN_W-1:0]  len_setting = LEN_RESET;
	logic              frame_open = 1'b0;
	logic              esc_held = 1'b0;
	logic [LEN_W-1:0]  payload_count = '0;

	slip_word_t        decoded_due [$];
	bit                idle_on = 1'b1;
	int unsigned       stall_left = 0;
	int unsigned       cycle_count = 0;
	int                words_sent = 0;
	int                err_count = 0;

	slip_frame_decoder_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.read_failed  (read_failed),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.has_byte     (has_byte),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.frame_done   (frame_done),
		.status       (status)
	);

	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side stalls in random bursts while idle_on is set
	always @(posedge clk) begin
		if (!idle_on) begin
			res_ready <= 1'b1;
		end else if (stall_left != 0) begin
			res_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			res_ready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			res_ready <= 1'b1;
		end
	end

	// compare each taken result word with the oldest one due
	always @(posedge clk) begin : result_check
		slip_word_t want;
		if (arst_n && res_valid === 1'b1 && res_ready) begin
			if (decoded_due.size() == 0) begin
				$error("result word with none due");
				err_count++;
			end else begin
				want = decoded_due.pop_front();
				if (has_byte !== want.has) begin
					$error("has_byte: expected %0h, got %0h", want.has, has_byte);
					err_count++;
				end
				if (payload_byte !== want.data) begin
					$error("payload_byte: expected %0h, got %0h", want.data, payload_byte);
					err_count++;
				end
				if (byte_index !== want.idx) begin
					$error("byte_index: expected %0d, got %0d", want.idx, byte_index);
					err_count++;
				end
				if (frame_done !== want.done) begin
					$error("frame_done: expected %0h, got %0h", want.done, frame_done);
					err_count++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					err_count++;
				end
			end
		end
	end

	// zero reads as 1, anything above the payload limit saturates
	function automatic logic [LEN_W-1:0] frame_limit();
		if (len_setting == '0)
			return 17'd1;
		if (len_setting > MAX_PAYLOAD)
			return MAX_PAYLOAD;
		return len_setting;
	endfunction

	function automatic void drop_frame();
		frame_open = 1'b0;
		esc_held = 1'b0;
		payload_count = '0;
	endfunction

	// advance the decoder by one receive word; returns 1 when a result is due
	function automatic bit decode_rx_word(input logic [7:0] b, input logic fail,
			output slip_word_t w);
		logic [7:0] plain;
		w = '0;
		if (fail) begin
			drop_frame();
			w.done = 1'b1;
			w.st = ST_FAIL;
			return 1'b1;
		end
		// hunting: only END counts
		if (!frame_open) begin
			if (b == FEND) begin
				frame_open = 1'b1;
				esc_held = 1'b0;
				payload_count = '0;
			end
			return 1'b0;
		end
		if (b == FEND) begin
			drop_frame();
			w.done = 1'b1;
			w.st = ST_SHORT;
			return 1'b1;
		end
		if (esc_held) begin
			esc_held = 1'b0;
			case (b)
				TEND: plain = FEND;
				TESC: plain = FESC;
				TLF: plain = LF;
				TCR: plain = CR;
				default: plain = b;
			endcase
		end else if (b == FESC) begin
			esc_held = 1'b1;
			return 1'b0;
		end else begin
			plain = b;
		end
		w.has = 1'b1;
		w.data = plain;
		w.idx = payload_count[IDX_W-1:0];
		payload_count = payload_count + 1'b1;
		if (payload_count >= frame_limit()) begin
			drop_frame();
			w.done = 1'b1;
		end
		return 1'b1;
	endfunction

	// payload byte biased toward the escape codes, never END
	function automatic logic [7:0] payload_pick();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: b = FESC;
			1: b = TEND;
			2: b = TESC;
			3: b = TLF;
			4: b = TCR;
			default: begin
				do
					b = 8'($urandom_range(0, 255));
				while (b == FEND);
			end
		endcase
		return b;
	endfunction

	// present one word, wait for the handshake, then record what it owes
	task automatic send_word(input logic [7:0] b, input logic fail,
			input row_chk_t chk = CHK_MODEL, input slip_word_t typed = '0);
		slip_word_t w;
		bit got;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		read_failed <= fail;
		do
			@(posedge clk);
		while (!rx_ready);
		words_sent++;
		got = decode_rx_word(b, fail, w);
		if (chk == CHK_WORD)
			decoded_due.push_back(typed);
		else if (chk == CHK_MODEL && got)
			decoded_due.push_back(w);
	endtask

	task automatic drain_words();
		rx_valid <= 1'b0;
		while (decoded_due.size() != 0)
			@(posedge clk);
	endtask

	// write expected_length while idle, then read it back
	task automatic write_length(input logic [31:0] word);
		logic [31:0] got;
		drain_words();
		// words with no result may still be in the pipe
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LEN_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		len_setting = word[LEN_W-1:0];
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got[LEN_W-1:0] !== word[LEN_W-1:0]) begin
			$error("expected_length: expected %0h, got %0h", word[LEN_W-1:0], got[LEN_W-1:0]);
			err_count++;
		end
	endtask

	// END, then payload until the frame closes or max_raw bytes are sent;
	// a frame still open is ended by END or a read failure
	task automatic send_frame(input int max_raw);
		int n;
		n = 0;
		send_word(FEND, 1'b0);
		while (frame_open && n < max_raw) begin
			send_word(payload_pick(), 1'b0);
			n++;
		end
		if (frame_open) begin
			if ($urandom_range(0, 2) == 0)
				send_word(FESC, 1'b0);
			if ($urandom_range(0, 2) == 0)
				send_word(8'($urandom_range(0, 255)), 1'b1);
			else
				send_word(FEND, 1'b0);
		end
	endtask

	// random mix of frames and noise under one length setting
	task automatic run_phase(input logic [31:0] len_word, input bit idle, input int n_words);
		int first;
		write_length(len_word);
		idle_on = idle;
		first = words_sent;
		while (words_sent - first < n_words) begin
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 3))
						send_word(($urandom_range(0, 3) == 0) ? FEND : 8'($urandom_range(0, 255)),
							$urandom_range(0, 4) == 0);
				end
				1, 2: send_frame($urandom_range(0, 10));
				default: send_frame((frame_limit() > 32) ? $urandom_range(0, 10) : 1 << 30);
			endcase
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].set_len)
				write_length(DIRECTED[i].len);
			send_word(DIRECTED[i].rx, DIRECTED[i].fail, DIRECTED[i].chk, DIRECTED[i].want);
		end

		// random phases over several lengths
		run_phase(32'd2, 1'b1, 100);
		run_phase(32'd1, 1'b1, 80);
		run_phase(32'd0, 1'b0, 60);
		run_phase(32'd5, 1'b1, 100);
		run_phase(32'h0001_0000, 1'b1, 80);
		// upper data bits are not part of the register
		run_phase(32'hFFFE_0003, 1'b1, 80);
		run_phase($urandom_range(6, 20), 1'b1, 120);

		// all-ones length saturates; a short frame under it ends early
		write_length(32'h0001_FFFF);
		idle_on = 1'b0;
		send_word(8'($urandom_range(0, 255)), 1'b1);
		send_frame($urandom_range(0, 10));

		// closing stretch without stalls
		run_phase($urandom_range(1, 8), 1'b0, 100);

		drain_words();
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== slip_frame_decoder_unit.f =====
+incdir+rtl
rtl/slip_dec_pkg.sv
rtl/slip_dec_cfg.sv
rtl/slip_dec_core.sv
rtl/slip_frame_decoder_unit.sv
sim/tb_top.sv
